### design/pbwt_pkg.sv
// Shared constants for the PBWT column update block.
package pbwt_pkg;

    // Default sizing of the index
    localparam int HAPLOTYPES_DEF  = 64;
    localparam int MARKER_BITS_DEF = 16;

    // Fixed field widths of the channels
    localparam int HAP_PORT_W = 6;
    localparam int COUNT_W    = 7;

    // Haplotype count after reset
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

endpackage

### design/pbwt_column_if.sv
// Input channel: one allele word per haplotype of the current column.
interface pbwt_column_if;
    logic valid;
    logic ready;
    logic restart;
    logic allele;

    modport source (output valid, restart, allele, input ready);
    modport sink (input valid, restart, allele, output ready);
endinterface

### design/pbwt_order_if.sv
// Output channel: one word per entry of the new prefix order.
interface pbwt_order_if #(
    parameter int DIV_W = pbwt_pkg::MARKER_BITS_DEF + 1
);
    import pbwt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [HAP_PORT_W-1:0] haplotype;
    logic [DIV_W-1:0]      divergence;
    logic                  last;

    modport source (output valid, haplotype, divergence, last, input ready);
    modport sink (input valid, haplotype, divergence, last, output ready);
endinterface

### design/pbwt_cfg_if.sv
// Configuration channel: writes the haplotype count register.
interface pbwt_cfg_if;
    import pbwt_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### design/pbwt_column_update.sv
// PBWT column update: stable partition of the prefix order per marker column.
//
// Alleles of one marker column are taken one word per cycle, haplotype 0 first, into a
// small allele memory. After the n-th allele (n = haplotype count, clamped to 2..HAPLOTYPES)
// the block walks the stored prefix order: the order/divergence memory is read once per
// cycle, its haplotype addresses the allele memory, and the third stage updates the two
// run starts and writes the entry to its place in the other bank of the order memory
// (zeros from position 0, ones from the zero tally counted during loading). The new order is
// then sent out, one word per cycle while the sink is ready, with last on the final entry;
// the next column may load while that happens. A column passes through the load, wait and
// walk states in that order. The memory read register doubles as the output register, so
// the next walk waits until the last word of the previous readout has left.
// restart (or any count write) returns to the identity order, zero divergences and marker 0
// without a clearing pass: a flag makes the next walk read identity entries.
module pbwt_column_update #(
    parameter int HAPLOTYPES  = pbwt_pkg::HAPLOTYPES_DEF,
    parameter int MARKER_BITS = pbwt_pkg::MARKER_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    pbwt_column_if.sink   column,
    pbwt_order_if.source  order,
    pbwt_cfg_if.sink      cfg
);
    import pbwt_pkg::*;

    localparam int IDX_W  = (HAPLOTYPES > 1) ? $clog2(HAPLOTYPES) : 1;
    localparam int CNT_W  = $clog2(HAPLOTYPES + 1);
    localparam int DIV_W  = MARKER_BITS + 1;
    localparam int WORD_W = IDX_W + DIV_W;
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 2 ** ADDR_W;

    localparam logic [MARKER_BITS-1:0] MARKER_MAX = '1;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    // Control state
    logic [1:0]             state_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic                   ident_reg;
    logic [IDX_W-1:0]       load_cnt_reg;
    logic [CNT_W-1:0]       tally_reg;
    logic [MARKER_BITS-1:0] marker_reg;
    logic                   bank_reg;
    logic [CNT_W-1:0]       walk_cnt_reg;
    logic                   b_v_reg;
    logic                   c_v_reg;
    logic                   c_last_reg;
    logic [CNT_W-1:0]       zpos_reg;
    logic [CNT_W-1:0]       opos_reg;
    logic                   emit_act_reg;
    logic [IDX_W-1:0]       emit_idx_reg;
    logic                   emit_bank_reg;
    logic                   out_valid_reg;
    logic                   out_last_reg;

    // Walk payload
    logic [IDX_W-1:0]       b_idx_reg;
    logic [IDX_W-1:0]       c_hap_reg;
    logic [DIV_W-1:0]       c_div_reg;
    logic [DIV_W-1:0]       zr_reg;
    logic [DIV_W-1:0]       or_reg;

    // Memories
    logic                   allele_mem [HAPLOTYPES];
    logic                   allele_q;
    logic [WORD_W-1:0]      order_mem [DEPTH];
    logic [WORD_W-1:0]      order_q;

    logic [CNT_W-1:0]       n_use;
    logic                   col_accept;
    logic                   cfg_accept;
    logic [IDX_W-1:0]       load_idx;
    logic [CNT_W-1:0]       tally_base;
    logic                   load_done;
    logic                   walk_issue;
    logic                   emit_rd;
    logic                   emit_end;
    logic [ADDR_W-1:0]      rd_addr;
    logic [IDX_W-1:0]       b_hap;
    logic [DIV_W-1:0]       b_div;
    logic [DIV_W-1:0]       z_max;
    logic [DIV_W-1:0]       o_max;
    logic [CNT_W-1:0]       wr_pos;
    logic [ADDR_W-1:0]      wr_addr;
    logic [DIV_W-1:0]       run_init;

    // Clamp the haplotype count to the supported range
    always_comb
    begin
        if (count_reg < COUNT_W'(2))
            n_use = CNT_W'(2);
        else if (count_reg > COUNT_W'(HAPLOTYPES))
            n_use = CNT_W'(HAPLOTYPES);
        else
            n_use = count_reg[CNT_W-1:0];
    end

    // Handshakes
    assign column.ready = (state_reg == ST_LOAD);
    assign cfg.ready    = 1'b1;
    assign col_accept   = column.valid && column.ready;
    assign cfg_accept   = cfg.valid && cfg.ready;

    // Load position and zero tally, restarted at each column start or by the word itself
    assign load_idx   = column.restart ? '0 : load_cnt_reg;
    assign tally_base = (column.restart || load_cnt_reg == '0) ? '0 : tally_reg;
    assign load_done  = (CNT_W'(load_idx) + CNT_W'(1)) >= n_use;

    // Memory read arbitration: walk and readout never overlap
    assign walk_issue = (state_reg == ST_WALK) && (walk_cnt_reg < n_use);
    assign emit_rd    = emit_act_reg && (!out_valid_reg || order.ready);
    assign emit_end   = CNT_W'(emit_idx_reg) == (n_use - CNT_W'(1));
    assign rd_addr    = walk_issue ? {bank_reg, walk_cnt_reg[IDX_W-1:0]}
                                   : {emit_bank_reg, emit_idx_reg};

    // Stage B: entry read from the order memory, or identity after a restart
    assign b_hap = ident_reg ? b_idx_reg : order_q[WORD_W-1:DIV_W];
    assign b_div = ident_reg ? '0 : order_q[DIV_W-1:0];

    // Stage C: fold the divergence into both run starts and place the entry
    assign z_max   = (c_div_reg > zr_reg) ? c_div_reg : zr_reg;
    assign o_max   = (c_div_reg > or_reg) ? c_div_reg : or_reg;
    assign wr_pos  = allele_q ? opos_reg : zpos_reg;
    assign wr_addr = {~bank_reg, wr_pos[IDX_W-1:0]};

    assign run_init = DIV_W'(marker_reg) + DIV_W'(1);

    // Allele memory: written while loading, read by the walk
    always_ff @(posedge clk)
    begin
        if (col_accept)
            allele_mem[load_idx] <= column.allele;
        if (b_v_reg)
            allele_q <= allele_mem[b_hap];
    end

    // Order/divergence memory: two banks, read one, write the other
    always_ff @(posedge clk)
    begin
        if (c_v_reg)
            order_mem[wr_addr] <= {c_hap_reg, allele_q ? o_max : z_max};
        if (walk_issue || emit_rd)
            order_q <= order_mem[rd_addr];
    end

    // Walk pipeline payload
    always_ff @(posedge clk)
    begin
        if (walk_issue)
            b_idx_reg <= walk_cnt_reg[IDX_W-1:0];
        if (b_v_reg)
        begin
            c_hap_reg <= b_hap;
            c_div_reg <= b_div;
        end
        if (state_reg == ST_WAIT)
        begin
            zr_reg <= run_init;
            or_reg <= run_init;
        end
        else if (c_v_reg)
        begin
            zr_reg <= allele_q ? z_max : '0;
            or_reg <= allele_q ? '0 : o_max;
        end
    end

    // Control: load, walk, readout
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= COUNT_RESET;
            ident_reg     <= 1'b1;
            load_cnt_reg  <= '0;
            tally_reg     <= '0;
            marker_reg    <= '0;
            bank_reg      <= 1'b0;
            walk_cnt_reg  <= '0;
            b_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            c_last_reg    <= 1'b0;
            zpos_reg      <= '0;
            opos_reg      <= '0;
            emit_act_reg  <= 1'b0;
            emit_idx_reg  <= '0;
            emit_bank_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            b_v_reg    <= walk_issue;
            c_v_reg    <= b_v_reg;
            c_last_reg <= b_v_reg && (CNT_W'(b_idx_reg) == (n_use - CNT_W'(1)));

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (col_accept)
                    begin
                        tally_reg    <= tally_base + CNT_W'(!column.allele);
                        load_cnt_reg <= load_done ? '0 : load_idx + IDX_W'(1);
                        if (column.restart)
                        begin
                            ident_reg  <= 1'b1;
                            marker_reg <= '0;
                        end
                        if (load_done)
                            state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    // hold until the previous column has been sent out
                    if (!emit_act_reg && !out_valid_reg)
                    begin
                        state_reg    <= ST_WALK;
                        walk_cnt_reg <= '0;
                        zpos_reg     <= '0;
                        opos_reg     <= tally_reg;
                    end
                end
                ST_WALK:
                begin
                    if (walk_issue)
                        walk_cnt_reg <= walk_cnt_reg + CNT_W'(1);
                    if (c_v_reg)
                    begin
                        if (allele_q)
                            opos_reg <= opos_reg + CNT_W'(1);
                        else
                            zpos_reg <= zpos_reg + CNT_W'(1);
                    end
                    // column done: swap banks, advance marker, start readout
                    if (c_v_reg && c_last_reg)
                    begin
                        state_reg     <= ST_LOAD;
                        ident_reg     <= 1'b0;
                        bank_reg      <= ~bank_reg;
                        emit_bank_reg <= ~bank_reg;
                        emit_act_reg  <= 1'b1;
                        emit_idx_reg  <= '0;
                        if (marker_reg != MARKER_MAX)
                            marker_reg <= marker_reg + MARKER_BITS'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase

            // Readout: memory read register doubles as the output register
            if (emit_rd)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= emit_end;
                emit_idx_reg  <= emit_idx_reg + IDX_W'(1);
                if (emit_end)
                    emit_act_reg <= 1'b0;
            end
            else if (order.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Count write restarts the index
            if (cfg_accept)
            begin
                count_reg    <= cfg.data;
                ident_reg    <= 1'b1;
                marker_reg   <= '0;
                load_cnt_reg <= '0;
                tally_reg    <= '0;
            end
        end
    end

    // Output word
    assign order.valid      = out_valid_reg;
    assign order.haplotype  = HAP_PORT_W'(order_q[WORD_W-1:DIV_W]);
    assign order.divergence = order_q[DIV_W-1:0];
    assign order.last       = out_last_reg;

    // The walk reuses the read register, so the output must be drained first
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (!out_valid_reg && !emit_act_reg))
        else $error("walk running while output still busy");

    // Every placed entry lands inside the column
    assert property (@(posedge clk) disable iff (!rst_n)
        c_v_reg |-> (wr_pos < n_use))
        else $error("walk write outside the column");

    // Zeros fill exactly the tally counted during loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_v_reg && c_last_reg) |=> (zpos_reg == tally_reg))
        else $error("zero run does not match loaded tally");

    // Last word ends the readout
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> !emit_act_reg)
        else $error("readout active after last word");

    // Load position stays inside the column
    assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(load_cnt_reg) < n_use)
        else $error("load position beyond column");

endmodule

### tb/tb_pbwt_column_update.sv
// Self-checking testbench for the PBWT column update block: predicts and checks each column.
module tb_pbwt_column_update;
    import pbwt_pkg::*;

    // Narrow marker field, so the divergence width differs from the default
    localparam int HAPS       = HAPLOTYPES_DEF;
    localparam int MBITS      = 8;
    localparam int DIV_W      = MBITS + 1;
    localparam int SETTLE     = 2 * HAPS + 16;
    localparam int LONG_HOLD  = 400;
    localparam int QUIET_MAX  = 4000;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic restart;
        logic allele;
    } allele_word_t;

    typedef struct packed {
        logic [HAP_PORT_W-1:0] hap;
        logic [DIV_W-1:0]      div;
        logic                  last;
    } order_word_t;

    typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES, FILL_SPARSE} fill_kind_t;

    logic clk = 1'b0;
    logic rst_n;

    pbwt_column_if                column_ch();
    pbwt_order_if #(.DIV_W(DIV_W)) order_ch();
    pbwt_cfg_if                   cfg_ch();

    pbwt_column_update #(
        .HAPLOTYPES  (HAPS),
        .MARKER_BITS (MBITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .column (column_ch),
        .order  (order_ch),
        .cfg    (cfg_ch)
    );

    // Shadow copy of the index
    logic [HAP_PORT_W-1:0] shadow_order [HAPS];
    logic [DIV_W-1:0]      shadow_div [HAPS];
    logic                  column_alleles [HAPS];
    logic [COUNT_W-1:0]    count_reg = COUNT_RESET;
    logic [MBITS-1:0]      marker;
    int                    load_pos;

    allele_word_t pending_alleles [$];
    order_word_t  expected_order [$];
    int           alleles_queued = 0;
    int           alleles_taken  = 0;
    int           mismatches     = 0;
    int           tx_idle_pct    = 0;
    int           rx_stall_pct   = 0;
    logic         long_hold_req  = 1'b0;
    logic         long_hold_ack;
    int           hold_left;
    int           quiet_cycles;

    always #5 clk = ~clk;

    function automatic int haps_in_use();
        if (count_reg < 2) return 2;
        if (count_reg > HAPS) return HAPS;
        return int'(count_reg);
    endfunction

    function automatic void restart_index();
        for (int i = 0; i < HAPS; i++)
        begin
            shadow_order[i] = HAP_PORT_W'(i);
            shadow_div[i]   = '0;
        end
        load_pos = 0;
        marker   = '0;
    endfunction

    // Stable partition of the stored order by this column's alleles
    function automatic void partition_column(int n);
        logic [DIV_W-1:0] zero_run;
        logic [DIV_W-1:0] one_run;
        logic [DIV_W-1:0] d;
        logic [HAP_PORT_W-1:0] h;
        order_word_t zeros [$];
        order_word_t ones [$];
        order_word_t w;
        int nz;
        zero_run = {1'b0, marker} + 1'b1;
        one_run  = zero_run;
        for (int i = 0; i < n; i++)
        begin
            h = shadow_order[i];
            d = shadow_div[i];
            if (d > zero_run) zero_run = d;
            if (d > one_run) one_run = d;
            if (column_alleles[h] == 1'b0)
            begin
                w = '{hap: h, div: zero_run, last: 1'b0};
                zeros.insert(zeros.size(), w);
                zero_run = '0;
            end
            else
            begin
                w = '{hap: h, div: one_run, last: 1'b0};
                ones.insert(ones.size(), w);
                one_run = '0;
            end
        end
        nz = zeros.size();
        for (int i = 0; i < n; i++)
        begin
            w = (i < nz) ? zeros[i] : ones[i - nz];
            w.last = (i == n - 1);
            shadow_order[i] = w.hap;
            shadow_div[i]   = w.div;
            expected_order.insert(expected_order.size(), w);
        end
        if (marker != '1) marker = marker + 1'b1;
    endfunction

    // Take one accepted allele word into the shadow index
    function automatic void take_allele(logic restart, logic allele);
        int n;
        n = haps_in_use();
        if (restart) restart_index();
        column_alleles[load_pos % HAPS] = allele;
        load_pos++;
        if (load_pos >= n)
        begin
            load_pos = 0;
            partition_column(n);
        end
    endfunction

    function automatic void push_word(logic restart, logic allele);
        allele_word_t w;
        w = '{restart: restart, allele: allele};
        pending_alleles.insert(pending_alleles.size(), w);
        alleles_queued++;
    endfunction

    function automatic logic fill_allele(fill_kind_t kind);
        case (kind)
            FILL_ZEROS:  return 1'b0;
            FILL_ONES:   return 1'b1;
            FILL_SPARSE: return ($urandom_range(7) == 0);
            default:     return 1'($urandom_range(1));
        endcase
    endfunction

    // Queue full columns of n alleles; with noise, add restarts and cut-off columns
    function automatic void queue_columns(int n, int cols, bit noise);
        fill_kind_t kind;
        logic restart;
        int cut;
        for (int c = 0; c < cols; c++)
        begin
            kind    = fill_kind_t'($urandom_range(3));
            restart = noise && ($urandom_range(5) == 0);
            if (noise && $urandom_range(9) == 0)
            begin
                cut = $urandom_range(n - 1, 1);
                for (int i = 0; i < cut; i++)
                    push_word(restart && i == 0, 1'($urandom_range(1)));
                restart = 1'b1;
            end
            for (int i = 0; i < n; i++)
                push_word(restart && i == 0, fill_allele(kind));
        end
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (alleles_taken != alleles_queued || expected_order.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        count_reg = value;
        restart_index();
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        @(posedge clk);
        tx_idle_pct  <= tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    // Allele sender: record the accepted word, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin : drive_alleles
        allele_word_t w;
        if (!rst_n)
        begin
            column_ch.valid   <= 1'b0;
            column_ch.restart <= 1'b0;
            column_ch.allele  <= 1'b0;
        end
        else
        begin
            if (column_ch.valid && column_ch.ready)
            begin
                take_allele(column_ch.restart, column_ch.allele);
                alleles_taken++;
            end
            if (!column_ch.valid || column_ch.ready)
            begin
                if (pending_alleles.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    w = pending_alleles.pop_front();
                    column_ch.valid   <= 1'b1;
                    column_ch.restart <= w.restart;
                    column_ch.allele  <= w.allele;
                end
                else
                    column_ch.valid <= 1'b0;
            end
        end
    end

    // Order receiver: random stalls plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_ch.ready <= 1'b0;
            hold_left      <= 0;
            long_hold_ack  <= 1'b0;
        end
        else if (long_hold_req && !long_hold_ack)
        begin
            hold_left      <= LONG_HOLD;
            long_hold_ack  <= 1'b1;
            order_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left      <= hold_left - 1;
            order_ch.ready <= 1'b0;
        end
        else
            order_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Compare each accepted order word with the oldest expected one
    always @(posedge clk)
    begin : check_order
        order_word_t exp_w;
        if (rst_n && order_ch.valid && order_ch.ready)
        begin
            if (expected_order.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("unexpected order word: hap %0d div %0d last %0b",
                             order_ch.haplotype, order_ch.divergence, order_ch.last);
            end
            else
            begin
                exp_w = expected_order.pop_front();
                if (order_ch.haplotype !== exp_w.hap || order_ch.divergence !== exp_w.div
                    || order_ch.last !== exp_w.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("order word wrong: expected hap %0d div %0d last %0b, %s",
                                 exp_w.hap, exp_w.div, exp_w.last,
                                 $sformatf("got hap %0d div %0d last %0b",
                                           order_ch.haplotype, order_ch.divergence,
                                           order_ch.last));
                end
            end
        end
    end

    // Drop the run if no word moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (column_ch.valid && column_ch.ready) || (order_ch.valid && order_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_MAX)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        for (int i = 0; i < HAPS; i++)
            column_alleles[i] = 1'b0;
        restart_index();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Count after reset: one full-width column
        queue_columns(HAPS, 1, 1'b0);
        wait_drained();

        // Count of zero acts as two: uniform, mixed and restarted columns
        write_count(7'd0);
        push_word(1'b0, 1'b0); push_word(1'b0, 1'b0);
        push_word(1'b0, 1'b1); push_word(1'b0, 1'b1);
        push_word(1'b0, 1'b1); push_word(1'b0, 1'b0);
        push_word(1'b0, 1'b0); push_word(1'b0, 1'b1);
        push_word(1'b0, 1'b1);
        push_word(1'b1, 1'b0); push_word(1'b0, 1'b1);
        wait_drained();

        // Count of one acts as two
        write_count(7'd1);
        push_word(1'b1, 1'b1); push_word(1'b0, 1'b0);
        push_word(1'b0, 1'b0); push_word(1'b0, 1'b1);
        wait_drained();

        // Count above the maximum acts as the maximum
        write_count(7'd127);
        set_idling(36, 36);
        queue_columns(HAPS, 1, 1'b1);
        wait_drained();

        write_count(7'd5);
        set_idling(84, 0);
        queue_columns(5, 2, 1'b1);
        wait_drained();

        write_count(COUNT_W'($urandom_range(4, 3)));
        set_idling(0, 84);
        queue_columns(haps_in_use(), 2, 1'b1);
        wait_drained();

        // Hold the order side off while columns keep coming
        write_count(7'd4);
        set_idling(0, 0);
        @(posedge clk);
        long_hold_req <= 1'b1;
        queue_columns(4, 3, 1'b0);
        wait_drained();

        write_count(COUNT_W'($urandom_range(3, 2)));
        set_idling(36, 36);
        queue_columns(haps_in_use(), 2, 1'b1);
        wait_drained();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### pbwt_column_update.f
design/pbwt_pkg.sv
design/pbwt_column_if.sv
design/pbwt_order_if.sv
design/pbwt_cfg_if.sv
design/pbwt_column_update.sv
tb/tb_pbwt_column_update.sv
